// File: src/gsi_pkg.sv
// ----------------------------------------------------------------------------
// gsi_pkg
// shared types and constants for the gini split impurity unit
// ----------------------------------------------------------------------------
package gsi_pkg;

    localparam int unsigned FRAC_W = 17;
    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_MASK      = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_DIV,
        BK_GINI,
        BK_WEIGHT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] index;
        logic       last;
    } job_t;

endpackage

// File: src/gsi_divider.sv
// ----------------------------------------------------------------------------
// gsi_divider
// restoring divider for q1.16 fractions, one quotient bit a cycle, clamped at one
// ----------------------------------------------------------------------------
module gsi_divider #(
    parameter int unsigned CW = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CW-1:0]              num,
    input  logic [CW-1:0]              den,
    output logic                       done,
    output logic [gsi_pkg::FRAC_W-1:0] quot
);
    import gsi_pkg::*;

    localparam int unsigned QW = CW + 16;
    localparam int unsigned CNT_W = $clog2(QW + 1);

    logic [CW:0]        rem_reg, rem_next;
    logic [QW-1:0]      q_reg, q_next;
    logic [QW-1:0]      n_reg, n_next;
    logic [CW-1:0]      d_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [CW:0]        trial;
    logic               zero_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        n_next    = n_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[CW-1:0], n_reg[QW-1]};
        if (start)
        begin
            rem_next  = '0;
            q_next    = '0;
            n_next    = {num, 16'h0000};
            cnt_next  = CNT_W'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[QW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        n_reg   <= n_next;
        if (start)
        begin
            d_reg    <= den;
            zero_reg <= (den == '0);
        end
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    // result valid the cycle after done
    assign quot = zero_reg ? '0 :
                  (q_reg > QW'(ONE_Q16)) ? ONE_Q16 : q_reg[FRAC_W-1:0];

endmodule

// File: src/gsi_front.sv
// ----------------------------------------------------------------------------
// gsi_front
// row acceptance and per-feature counters, queues a result job on the last row
// ----------------------------------------------------------------------------
module gsi_front #(
    parameter int unsigned NUM_FEATURES = 32,
    parameter int unsigned COUNT_WIDTH  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [31:0]                         feature_bits,
    input  logic                                label_positive,
    input  logic                                row_selected,
    input  logic                                last_row,
    output logic                                job_pending,
    input  logic                                job_taken,
    output logic [NUM_FEATURES*COUNT_WIDTH-1:0] snap_d,
    output logic [NUM_FEATURES*COUNT_WIDTH-1:0] snap_pw,
    output logic [NUM_FEATURES*COUNT_WIDTH-1:0] snap_pn
);
    import gsi_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [COUNT_WIDTH-1:0] d_reg  [NUM_FEATURES];
    logic [COUNT_WIDTH-1:0] pw_reg [NUM_FEATURES];
    logic [COUNT_WIDTH-1:0] pn_reg [NUM_FEATURES];
    logic                   pend_reg;
    logic                   fire;

    // one queued snapshot; a new row waits while the back part still needs it
    assign in_ready    = !pend_reg || job_taken;
    assign fire        = in_valid && in_ready;
    assign job_pending = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            for (int i = 0; i < NUM_FEATURES; i++)
            begin
                d_reg[i]  <= '0;
                pw_reg[i] <= '0;
                pn_reg[i] <= '0;
            end
        end
        else
        begin
            if (job_taken)
            begin
                pend_reg <= 1'b0;
            end
            if (fire)
            begin
                for (int i = 0; i < NUM_FEATURES; i++)
                begin
                    logic [COUNT_WIDTH-1:0] d_v, pw_v, pn_v;
                    d_v  = d_reg[i];
                    pw_v = pw_reg[i];
                    pn_v = pn_reg[i];
                    if (row_selected)
                    begin
                        if (feature_bits[i])
                        begin
                            if (d_v != CMAX) d_v = d_v + 1'b1;
                            if (label_positive && pw_v != CMAX) pw_v = pw_v + 1'b1;
                        end
                        else if (label_positive && pn_v != CMAX)
                        begin
                            pn_v = pn_v + 1'b1;
                        end
                    end
                    if (last_row)
                    begin
                        snap_d[i*COUNT_WIDTH +: COUNT_WIDTH]  <= d_v;
                        snap_pw[i*COUNT_WIDTH +: COUNT_WIDTH] <= pw_v;
                        snap_pn[i*COUNT_WIDTH +: COUNT_WIDTH] <= pn_v;
                        d_reg[i]  <= '0;
                        pw_reg[i] <= '0;
                        pn_reg[i] <= '0;
                    end
                    else
                    begin
                        d_reg[i]  <= d_v;
                        pw_reg[i] <= pw_v;
                        pn_reg[i] <= pn_v;
                    end
                end
                if (last_row)
                begin
                    pend_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: src/gsi_back.sv
// ----------------------------------------------------------------------------
// gsi_back
// per-feature impurity sequencer: shared divider, multiplier steps, output register
// ----------------------------------------------------------------------------
module gsi_back #(
    parameter int unsigned NUM_FEATURES = 32,
    parameter int unsigned COUNT_WIDTH  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_pending,
    output logic                                job_taken,
    input  logic [NUM_FEATURES*COUNT_WIDTH-1:0] snap_d,
    input  logic [NUM_FEATURES*COUNT_WIDTH-1:0] snap_pw,
    input  logic [NUM_FEATURES*COUNT_WIDTH-1:0] snap_pn,
    input  logic [15:0]                         row_count,
    input  logic [31:0]                         enable_mask,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [4:0]                          feature_index,
    output logic [15:0]                         impurity_value,
    output logic                                feature_used,
    output logic                                last_feature
);
    import gsi_pkg::*;

    localparam int unsigned MW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int unsigned FI_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

    back_state_t            state_reg, state_next;
    logic [FI_W-1:0]        fi_reg, fi_next;
    logic [1:0]             ph_reg, ph_next;
    logic                   wait_reg, wait_next;
    logic                   taken_reg, taken_next;
    logic [COUNT_WIDTH-1:0] d_reg, pw_reg, pn_reg;
    logic [MW-1:0]          rest_reg;
    logic [MW-1:0]          m_ext;
    logic [FRAC_W-1:0]      p_reg, p1_reg, p2_reg;
    logic [15:0]            g1_reg, g2_reg;
    logic [16:0]            t1_reg;
    logic [17:0]            sum;
    logic                   ov_reg, ov_next;
    job_t                   out_reg;
    logic [15:0]            val_reg;
    logic                   used_reg;
    logic                   dv_start, dv_done;
    logic [MW-1:0]          dv_num, dv_den;
    logic [FRAC_W-1:0]      dv_q;
    logic [33:0]            gmul;
    logic [33:0]            wmul;
    logic                   load, emit_en, cap_p, cap_p1, cap_p2, cap_g, cap_w1;

    gsi_divider #(.CW(MW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quot  (dv_q)
    );

    assign m_ext = MW'(row_count);

    always_comb
    begin
        case (ph_reg)
            2'd0:
            begin
                dv_num = MW'(d_reg);
                dv_den = m_ext;
            end
            2'd1:
            begin
                dv_num = MW'(pw_reg);
                dv_den = MW'(d_reg);
            end
            default:
            begin
                dv_num = MW'(pn_reg);
                dv_den = rest_reg;
            end
        endcase
    end

    // divider runs at the wider of the counter and denominator widths
    logic [MW-1:0] d_ext;
    logic [MW-1:0] num_p;
    assign d_ext = MW'(d_reg);
    assign num_p = d_ext;

    assign gmul = 34'(ph_reg == 2'd0 ? p1_reg : p2_reg) *
                  34'(ONE_Q16 - (ph_reg == 2'd0 ? p1_reg : p2_reg));
    assign wmul = (ph_reg == 2'd0) ? 34'(p_reg) * 34'(g1_reg)
                                   : 34'(ONE_Q16 - p_reg) * 34'(g2_reg);
    assign sum  = 18'(t1_reg) + 18'(wmul[33:16]);

    always_comb
    begin
        state_next = state_reg;
        fi_next    = fi_reg;
        ph_next    = ph_reg;
        wait_next  = 1'b0;
        taken_next = 1'b0;
        ov_next    = ov_reg;
        dv_start   = 1'b0;
        load = 1'b0; emit_en = 1'b0;
        cap_p = 1'b0; cap_p1 = 1'b0; cap_p2 = 1'b0; cap_g = 1'b0; cap_w1 = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_pending && !taken_reg)
                begin
                    fi_next    = '0;
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                load       = 1'b1;
                ph_next    = 2'd0;
                state_next = BK_DIV;
                wait_next  = 1'b1;
            end
            BK_DIV:
            begin
                if (wait_reg)
                begin
                    dv_start = 1'b1;
                end
                else if (ov_reg)
                begin
                    ov_next = 1'b0;
                    if (ph_reg == 2'd0) cap_p = 1'b1;
                    else if (ph_reg == 2'd1) cap_p1 = 1'b1;
                    else cap_p2 = 1'b1;
                    if (ph_reg == 2'd2)
                    begin
                        ph_next    = 2'd0;
                        state_next = BK_GINI;
                    end
                    else
                    begin
                        ph_next   = ph_reg + 2'd1;
                        wait_next = 1'b1;
                    end
                end
                else if (dv_done)
                begin
                    ov_next = 1'b1;
                end
            end
            BK_GINI:
            begin
                cap_g = 1'b1;
                if (ph_reg == 2'd1)
                begin
                    ph_next    = 2'd0;
                    state_next = BK_WEIGHT;
                end
                else
                begin
                    ph_next = 2'd1;
                end
            end
            BK_WEIGHT:
            begin
                if (ph_reg == 2'd0)
                begin
                    cap_w1  = 1'b1;
                    ph_next = 2'd1;
                end
                else if (!out_reg.valid || out_ready)
                begin
                    emit_en = 1'b1;
                    if (fi_reg == FI_W'(NUM_FEATURES - 1))
                    begin
                        taken_next = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        fi_next    = fi_reg + 1'b1;
                        state_next = BK_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign job_taken = taken_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            fi_reg    <= '0;
            ph_reg    <= '0;
            wait_reg  <= 1'b0;
            taken_reg <= 1'b0;
            ov_reg    <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fi_reg    <= fi_next;
            ph_reg    <= ph_next;
            wait_reg  <= wait_next;
            taken_reg <= taken_next;
            ov_reg    <= ov_next;
            if (emit_en)
            begin
                out_reg.valid <= 1'b1;
                out_reg.index <= 5'(fi_reg);
                out_reg.last  <= (fi_reg == FI_W'(NUM_FEATURES - 1));
            end
            else if (out_ready)
            begin
                out_reg.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            d_reg  <= snap_d[fi_reg*COUNT_WIDTH +: COUNT_WIDTH];
            pw_reg <= snap_pw[fi_reg*COUNT_WIDTH +: COUNT_WIDTH];
            pn_reg <= snap_pn[fi_reg*COUNT_WIDTH +: COUNT_WIDTH];
            if (MW'(snap_d[fi_reg*COUNT_WIDTH +: COUNT_WIDTH]) >= m_ext)
                rest_reg <= '0;
            else
                rest_reg <= m_ext - MW'(snap_d[fi_reg*COUNT_WIDTH +: COUNT_WIDTH]);
        end
        if (cap_p)
        begin
            // p uses m as divisor, which may be wider than the counters
            p_reg <= (num_p >= m_ext) ? ((m_ext == '0) ? '0 : ONE_Q16) : dv_q;
        end
        if (cap_p1) p1_reg <= dv_q;
        if (cap_p2) p2_reg <= dv_q;
        if (cap_g)
        begin
            if (ph_reg == 2'd0) g1_reg <= gmul[30:15];
            else                g2_reg <= gmul[30:15];
        end
        if (cap_w1) t1_reg <= wmul[32:16];
        if (emit_en)
        begin
            used_reg <= enable_mask[fi_reg];
            if (!enable_mask[fi_reg])  val_reg <= '0;
            else if (sum > 18'd65535)  val_reg <= 16'hFFFF;
            else                       val_reg <= sum[15:0];
        end
    end

    assign out_valid      = out_reg.valid;
    assign feature_index  = out_reg.index;
    assign last_feature   = out_reg.last;
    assign impurity_value = val_reg;
    assign feature_used   = used_reg;

endmodule

// File: src/gini_split_impurity_unit.sv
// ----------------------------------------------------------------------------
// gini_split_impurity_unit
// weighted gini impurity of binary splits over a stream of training rows
// ----------------------------------------------------------------------------
// Rows transfer at one per cycle and update all feature counters at once. The
// last row snapshots the counters into a one-deep job queue and the back part
// then produces one result per feature, with three fractions through one
// shared bit-serial divider on W-bit operands, W the larger of COUNT_WIDTH and
// 16; the receiver can hold the results back. While a job is queued the input
// stalls; rows are accepted again once the last feature's result has gone to
// the output register.
module gini_split_impurity_unit #(
    parameter int unsigned NUM_FEATURES = 32,
    parameter int unsigned COUNT_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] feature_bits,
    input  logic        label_positive,
    input  logic        row_selected,
    input  logic        last_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  feature_index,
    output logic [15:0] impurity_value,
    output logic        feature_used,
    output logic        last_feature
);
    import gsi_pkg::*;

    logic [15:0] row_count_reg;
    logic [31:0] mask_reg;
    logic        job_pending, job_taken;
    logic [NUM_FEATURES*COUNT_WIDTH-1:0] snap_d, snap_pw, snap_pn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            mask_reg      <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data[15:0];
                CFG_MASK:      mask_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    gsi_front #(.NUM_FEATURES(NUM_FEATURES), .COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .feature_bits(feature_bits), .label_positive(label_positive),
        .row_selected(row_selected), .last_row(last_row),
        .job_pending(job_pending), .job_taken(job_taken),
        .snap_d(snap_d), .snap_pw(snap_pw), .snap_pn(snap_pn)
    );

    gsi_back #(.NUM_FEATURES(NUM_FEATURES), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_pending(job_pending), .job_taken(job_taken),
        .snap_d(snap_d), .snap_pw(snap_pw), .snap_pn(snap_pn),
        .row_count(row_count_reg), .enable_mask(mask_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .feature_index(feature_index), .impurity_value(impurity_value),
        .feature_used(feature_used), .last_feature(last_feature)
    );

endmodule

// File: src/gsi_checker.sv
// ----------------------------------------------------------------------------
// gsi_checker
// port-level checks on the result stream
// ----------------------------------------------------------------------------
module gsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  feature_index,
    input logic [15:0] impurity_value,
    input logic        feature_used
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(feature_index))
        else $error("result dropped while stalled");
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !feature_used |-> impurity_value == 16'h0000)
        else $error("disabled feature with nonzero impurity");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid && feature_index != 5'd0
        |-> feature_index != $past(feature_index))
        else $error("result repeated");
endmodule

bind gini_split_impurity_unit gsi_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .feature_index(feature_index), .impurity_value(impurity_value),
    .feature_used(feature_used)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the gini split impurity unit. Training rows go in as valid/ready
// transfers with random gaps, and the receiver stalls at random. A model in
// the testbench keeps its own feature counters and register copies and
// predicts the 32 impurity results that each last row produces. Every result
// is compared field by field. The stimulus is a directed table, then a
// back-pressure burst, then random nodes under a range of register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import gsi_pkg::*;

    localparam int unsigned NFEAT      = 32;
    localparam int unsigned CNT_MAX    = 65535;
    localparam longint     ONE        = 65536;
    localparam int unsigned DRAIN_WAIT = 4000;
    localparam longint     CYCLE_LIMIT = 3000000;

    typedef enum logic { ST_ROW, ST_CFG } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic        reg_sel;
        logic [31:0] reg_val;
        logic [31:0] bits;
        logic        pos;
        logic        sel;
        logic        last;
        logic        typed_zero;
    } stim_step_t;

    typedef struct {
        logic [4:0]  index;
        logic [15:0] value;
        logic        used;
        logic        last;
    } split_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_ROW_COUNT;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] feature_bits = '0;
    logic        label_positive = 1'b0;
    logic        row_selected = 1'b0;
    logic        last_row = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  feature_index;
    logic [15:0] impurity_value;
    logic        feature_used;
    logic        last_feature;

    int unsigned   row_count_reg;
    logic [31:0]   enable_mask_reg;
    int unsigned   with_cnt [NFEAT];
    int unsigned   pos_with_cnt [NFEAT];
    int unsigned   pos_without_cnt [NFEAT];
    split_result_t pending_results [$];
    int unsigned   mismatches = 0;
    int unsigned   hold_off = 0;
    longint        cycles = 0;

    gini_split_impurity_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .feature_bits(feature_bits),
        .label_positive(label_positive),
        .row_selected(row_selected),
        .last_row(last_row),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .feature_index(feature_index),
        .impurity_value(impurity_value),
        .feature_used(feature_used),
        .last_feature(last_feature)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gini_split_impurity_unit verification failed");
            $finish;
        end
    end

    function automatic longint q16_fraction(longint num, longint den);
        longint f;
        if (den == 0)
            return 0;
        f = (num * ONE) / den;
        return (f > ONE) ? ONE : f;
    endfunction

    function automatic longint q16_gini(longint p);
        return (2 * p * (ONE - p)) >> 16;
    endfunction

    function automatic logic [15:0] split_impurity(int unsigned f);
        longint m, d, rest, share, p_with, p_without, s;
        m = row_count_reg;
        d = with_cnt[f];
        rest = (d >= m) ? 0 : m - d;
        share = q16_fraction(d, m);
        p_with = q16_fraction(pos_with_cnt[f], d);
        p_without = q16_fraction(pos_without_cnt[f], rest);
        s = ((share * q16_gini(p_with)) >> 16) + (((ONE - share) * q16_gini(p_without)) >> 16);
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void count_row(logic [31:0] bits, logic pos, logic sel, logic last,
                                      logic typed_zero);
        split_result_t r;
        if (sel)
            for (int f = 0; f < NFEAT; f++)
            begin
                if (bits[f])
                begin
                    if (with_cnt[f] < CNT_MAX) with_cnt[f]++;
                    if (pos && pos_with_cnt[f] < CNT_MAX) pos_with_cnt[f]++;
                end
                else if (pos && pos_without_cnt[f] < CNT_MAX)
                    pos_without_cnt[f]++;
            end
        if (last)
        begin
            for (int f = 0; f < NFEAT; f++)
            begin
                r.index = f[4:0];
                r.used = enable_mask_reg[f];
                r.value = (typed_zero || !r.used) ? 16'h0 : split_impurity(f);
                r.last = (f == NFEAT - 1);
                pending_results.push_back(r);
            end
            for (int f = 0; f < NFEAT; f++)
            begin
                with_cnt[f] = 0;
                pos_with_cnt[f] = 0;
                pos_without_cnt[f] = 0;
            end
        end
    endfunction

    // result side: random stalls plus a long hold-off on request
    initial
    begin
        split_result_t want;
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: index %0d value %0d", feature_index,
                                 impurity_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (feature_index !== want.index || impurity_value !== want.value ||
                        feature_used !== want.used || last_feature !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: exp idx %0d val %0d used %0d last %0d,",
                                      " got idx %0d val %0d used %0d last %0d"},
                                     want.index, want.value, want.used, want.last,
                                     feature_index, impurity_value, feature_used, last_feature);
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                        : $urandom_range(10, 60);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_row(logic [31:0] bits, logic pos, logic sel, logic last,
                            logic typed_zero);
        in_valid <= 1'b1;
        feature_bits <= bits;
        label_positive <= pos;
        row_selected <= sel;
        last_row <= last;
        do
            @(posedge clk);
        while (!in_ready);
        count_row(bits, pos, sel, last, typed_zero);
    endtask

    task automatic row_gap(bit quiet);
        int unsigned n;
        if (quiet || $urandom_range(0, 99) < 55)
            return;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 50);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic sel, logic [31:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_ROW_COUNT)
            row_count_reg = val[15:0];
        else
            enable_mask_reg = val;
    endtask

    task automatic random_node(int unsigned rows, bit quiet);
        logic [31:0] bits;
        for (int r = 0; r < rows; r++)
        begin
            case ($urandom_range(0, 7))
                0: bits = '1;
                1: bits = '0;
                default: bits = $urandom;
            endcase
            send_row(bits, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
                     r == rows - 1, 1'b0);
            row_gap(quiet);
        end
    endtask

    stim_step_t directed [] = '{
        // after reset: nothing counted, denominator zero
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1},
        // all features disabled
        '{ST_CFG, CFG_ROW_COUNT, 32'd4, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ST_CFG, CFG_MASK, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'h1234_5678, 1'b0, 1'b1, 1'b1, 1'b1},
        // balanced node of four rows
        '{ST_CFG, CFG_MASK, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'hAAAA_5555, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'h5555_AAAA, 1'b1, 1'b0, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'h0F0F_F0F0, 1'b0, 1'b1, 1'b1, 1'b0},
        // more counted rows than the denominator
        '{ST_CFG, CFG_ROW_COUNT, 32'd1, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'hFF00_FF00, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'hF0F0_F0F0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'hCCCC_3333, 1'b1, 1'b1, 1'b1, 1'b0},
        // widest denominator, partial mask
        '{ST_CFG, CFG_ROW_COUNT, 32'hFFFF, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ST_CFG, CFG_MASK, 32'h8000_0001, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'h8000_0001, 1'b1, 1'b1, 1'b0, 1'b0},
        '{ST_ROW, CFG_ROW_COUNT, 32'h0, 32'h7FFF_FFFE, 1'b1, 1'b1, 1'b1, 1'b0}
    };

    initial
    begin
        row_count_reg = 0;
        enable_mask_reg = '1;
        for (int f = 0; f < NFEAT; f++)
        begin
            with_cnt[f] = 0;
            pos_with_cnt[f] = 0;
            pos_without_cnt[f] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            if (directed[k].kind == ST_CFG)
                write_reg(directed[k].reg_sel, directed[k].reg_val);
            else
            begin
                send_row(directed[k].bits, directed[k].pos, directed[k].sel, directed[k].last,
                         directed[k].typed_zero);
                row_gap(1'b0);
            end
        end

        // back-pressure: results held off while further nodes queue up
        write_reg(CFG_MASK, 32'hFFFF_FFFF);
        write_reg(CFG_ROW_COUNT, 32'd6);
        hold_off = 9000;
        for (int n = 0; n < 4; n++)
            random_node(3, 1'b1);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: write_reg(CFG_ROW_COUNT, 32'd8);
                1: write_reg(CFG_ROW_COUNT, 32'd0);
                2: write_reg(CFG_MASK, $urandom);
                3: write_reg(CFG_ROW_COUNT, 32'hFFFF);
                4: write_reg(CFG_MASK, 32'hFFFF_FFFF);
                5: write_reg(CFG_ROW_COUNT, $urandom_range(1, 40));
                6: write_reg(CFG_MASK, $urandom);
                default: write_reg(CFG_ROW_COUNT, $urandom_range(2, 12));
            endcase
            for (int n = 0; n < 3; n++)
                random_node($urandom_range(1, 12), phase == 4);
        end

        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("gini_split_impurity_unit verification clean");
        else
            $display("gini_split_impurity_unit verification failed");
        $finish;
    end

endmodule
